// ===== sv/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue core.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

	// Ring depth and derived widths
	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int WORD_W  = 32;
	localparam int COUNT_W = 5;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam idx_t IDX_LAST = IDX_W'(DEPTH - 1);
	localparam cnt_t CNT_FULL = CNT_W'(DEPTH);

	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_BACK   = 2'd2,
		OP_POP_FRONT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Memory request issued by the index controller for one beat
	typedef struct packed {
		logic    wr_en;
		idx_t    wr_addr;
		idx_t    front_addr;
		idx_t    back_addr;
		cnt_t    count;
		status_t status;
	} deq_req_t;

endpackage

`default_nettype wire

// ===== sv/deq_if.sv =====
// ----------------------------------------------------------------------------
// deq_if
// Valid/ready channels: operation requests in, queue snapshots out.
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_in_if import deq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               operation;
	logic signed [WORD_W-1:0] push_value;

	modport source (output valid, output operation, output push_value, input ready);
	modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface deq_out_if import deq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] front_word;
	logic signed [WORD_W-1:0] back_word;
	logic [COUNT_W-1:0]       entry_count;
	logic [1:0]               status;

	modport source (output valid, output front_word, output back_word,
		output entry_count, output status, input ready);
	modport sink   (input valid, input front_word, input back_word,
		input entry_count, input status, output ready);
endinterface

`default_nettype wire

// ===== sv/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Ring index and fill count bookkeeping; issues the write and the two reads.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl import deq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic accept,
	input  wire op_t  op,
	output deq_req_t  req
);

	idx_t front_q, back_q;
	cnt_t count_q;

	idx_t front_inc, front_dec, back_inc, back_dec;
	idx_t front_nxt, back_nxt, wr_addr;
	cnt_t count_nxt;
	logic full, empty, wr_en;
	status_t status;

	// Wrapping neighbors of both ends
	always_comb begin
		front_inc = (front_q == IDX_LAST) ? '0 : front_q + idx_t'(1);
		front_dec = (front_q == '0) ? IDX_LAST : front_q - idx_t'(1);
		back_inc  = (back_q == IDX_LAST) ? '0 : back_q + idx_t'(1);
		back_dec  = (back_q == '0) ? IDX_LAST : back_q - idx_t'(1);
		full      = (count_q == CNT_FULL);
		empty     = (count_q == '0);
	end

	// Next indices, count and write request for the current beat
	always_comb begin
		front_nxt = front_q;
		back_nxt  = back_q;
		count_nxt = count_q;
		wr_en     = 1'b0;
		wr_addr   = back_inc;
		status    = ST_DONE;
		unique case (op)
			OP_PUSH_BACK: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					wr_en     = 1'b1;
					wr_addr   = back_inc;
					back_nxt  = back_inc;
					count_nxt = count_q + cnt_t'(1);
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					wr_en     = 1'b1;
					wr_addr   = front_dec;
					front_nxt = front_dec;
					count_nxt = count_q + cnt_t'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					back_nxt  = back_dec;
					count_nxt = count_q - cnt_t'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					front_nxt = front_inc;
					count_nxt = count_q - cnt_t'(1);
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	assign req = '{
		wr_en:      wr_en,
		wr_addr:    wr_addr,
		front_addr: front_nxt,
		back_addr:  back_nxt,
		count:      count_nxt,
		status:     status
	};

	// Ring state; back starts one slot behind front
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= IDX_LAST;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_nxt;
			back_q  <= back_nxt;
			count_q <= count_nxt;
		end
	end

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("fill count above depth");

	a_drop_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		accept && full && (op == OP_PUSH_BACK || op == OP_PUSH_FRONT)
		|=> $stable(count_q) && $stable(front_q) && $stable(back_q))
		else $error("dropped push changed ring state");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> back_q == front_dec)
		else $error("empty ring with misplaced back index");

	a_ignored_pop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && empty && (op == OP_POP_BACK || op == OP_POP_FRONT)
		|=> $stable(front_q) && $stable(back_q) && count_q == '0)
		else $error("ignored pop changed ring state");

endmodule

`default_nettype wire

// ===== sv/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded deque of 32-bit words in a ring buffer; one snapshot per operation.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                      | handshake
//  req     | in  | operation, push_value                        | valid/ready
//  rsp     | out | front_word, back_word, entry_count, status   | valid/ready
//
//  One operation per cycle unless rsp stalls; each result passes through the read stage and then the output register.
//  Two mirrored RAMs give the front and back reads; a same-cycle write to a
//  read address is forwarded. Reset sets indices and clears count, not the RAMs.
//  A stalled rsp holds the output register and the read stage; req.ready
//  drops only when both are full and rsp is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_core import deq_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	deq_in_if.sink   req,
	deq_out_if.source rsp
);

	deq_req_t mreq;
	logic accept, adv;
	logic fwd_front, fwd_back;
	logic [WORD_W-1:0] front_rd, back_rd;

	// Read stage
	logic                     v_s1;
	logic                     fwd_front_s1, fwd_back_s1;
	logic [WORD_W-1:0]        val_s1;
	cnt_t                     cnt_s1;
	status_t                  st_s1;

	// Output register
	logic                     out_v_q;
	logic signed [WORD_W-1:0] front_word_q, back_word_q;
	logic [COUNT_W-1:0]       count_q;
	status_t                  status_q;

	// Handshake
	assign adv       = !out_v_q || rsp.ready;
	assign req.ready = !v_s1 || adv;
	assign accept    = req.valid && req.ready;

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.op     (op_t'(req.operation)),
		.req    (mreq)
	);

	// Mirrored word stores, one read port each
	deq_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram_front (
		.clk   (clk),
		.we    (accept && mreq.wr_en),
		.waddr (mreq.wr_addr),
		.wdata (req.push_value),
		.re    (accept),
		.raddr (mreq.front_addr),
		.rdata (front_rd)
	);

	deq_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram_back (
		.clk   (clk),
		.we    (accept && mreq.wr_en),
		.waddr (mreq.wr_addr),
		.wdata (req.push_value),
		.re    (accept),
		.raddr (mreq.back_addr),
		.rdata (back_rd)
	);

	// Write hitting a read address in the same beat
	assign fwd_front = mreq.wr_en && (mreq.wr_addr == mreq.front_addr);
	assign fwd_back  = mreq.wr_en && (mreq.wr_addr == mreq.back_addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_front_s1 <= fwd_front;
			fwd_back_s1  <= fwd_back;
			val_s1       <= req.push_value;
			cnt_s1       <= mreq.count;
			st_s1        <= mreq.status;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			if (cnt_s1 == '0) begin
				front_word_q <= '1;
				back_word_q  <= '1;
			end else begin
				front_word_q <= fwd_front_s1 ? val_s1 : front_rd;
				back_word_q  <= fwd_back_s1 ? val_s1 : back_rd;
			end
			count_q  <= COUNT_W'(cnt_s1);
			status_q <= st_s1;
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.front_word  = front_word_q;
	assign rsp.back_word   = back_word_q;
	assign rsp.entry_count = count_q;
	assign rsp.status      = status_q;

	// Checks
	a_empty_words: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && count_q == '0 |-> front_word_q == '1 && back_word_q == '1)
		else $error("empty snapshot with stored words");

	a_ignored_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && status_q == ST_EMPTY |-> count_q == '0)
		else $error("ignored pop on a non-empty queue");

	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && count_q == COUNT_W'(1) |-> front_word_q == back_word_q)
		else $error("front and back differ with one word stored");

	a_stage_fill: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(cnt_s1) && $stable(st_s1))
		else $error("read stage lost a stalled beat");

endmodule

`default_nettype wire

// ===== sim/double_ended_queue_core_test.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_core_test
// Drives push/pop beats into the deque core with random source gaps and sink
// stalls. A short directed table covers empty pops, word extremes, a wrap of
// the ring in both directions and pushes on a full queue. Random traffic
// follows, swinging between filling and draining phases. Every snapshot is
// compared field by field with an in-order queue of predicted snapshots.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_core_test import deq_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BEATS = 1150;
	localparam int CYCLE_LIMIT  = 500000;

	// One queue snapshot as reported on rsp
	typedef struct {
		logic [WORD_W-1:0]  front;
		logic [WORD_W-1:0]  back;
		logic [COUNT_W-1:0] count;
		status_t            st;
	} snap_t;

	// One directed stimulus row; pinned rows carry a hand-written snapshot
	typedef struct {
		op_t               op;
		logic [WORD_W-1:0] val;
		bit                pinned;
		snap_t             want;
	} row_t;

	logic clk;
	logic arst_n;

	deq_in_if  req_ch ();
	deq_out_if rsp_ch ();

	double_ended_queue_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the deque
	logic [WORD_W-1:0] ring [DEPTH];
	idx_t              head = '0;
	int unsigned       fill = 0;

	snap_t       pending_snaps [$];
	row_t        plan [$];
	bit          pin_valid = 1'b0;
	snap_t       pin_snap;
	int          fault_count = 0;
	int unsigned cycles = 0;
	int          src_calm = 0;
	int          snk_calm = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Apply one operation to the shadow deque and report the snapshot after it
	task automatic advance_deque(input op_t op, input logic [WORD_W-1:0] val,
		output snap_t s);
		idx_t slot;
		s.st = ST_DONE;
		case (op)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (fill >= DEPTH) begin
					s.st = ST_FULL;
				end else if (op == OP_PUSH_BACK) begin
					slot = head + idx_t'(fill);
					ring[slot] = val;
					fill++;
				end else begin
					head = head - 1'b1;
					ring[head] = val;
					fill++;
				end
			end
			default: begin
				if (fill == 0) begin
					s.st = ST_EMPTY;
				end else if (op == OP_POP_BACK) begin
					fill--;
				end else begin
					head = head + 1'b1;
					fill--;
				end
			end
		endcase
		if (fill == 0) begin
			s.front = '1;
			s.back  = '1;
		end else begin
			s.front = ring[head];
			s.back  = ring[head + idx_t'(fill - 1)];
		end
		s.count = COUNT_W'(fill);
	endtask

	function automatic void check_field(string field, logic [WORD_W-1:0] want,
		logic [WORD_W-1:0] got);
		if (got !== want) begin
			fault_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		end
	endfunction

	// Gap length: mostly none or short, now and then long
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 2);
		else if (r < 97)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	// Words biased toward the extremes and the all-ones empty marker
	function automatic logic [WORD_W-1:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 32'h7FFF_FFFF;
		else if (r < 16)
			return 32'h8000_0000;
		else if (r < 26)
			return 32'hFFFF_FFFF;
		else if (r < 32)
			return 32'h0000_0000;
		return $urandom;
	endfunction

	task automatic add_row(input op_t op, input logic [WORD_W-1:0] val);
		row_t row;
		row.op     = op;
		row.val    = val;
		row.pinned = 1'b0;
		row.want   = '{'1, '1, '0, ST_DONE};
		plan.push_back(row);
	endtask

	task automatic add_pinned(input op_t op, input logic [WORD_W-1:0] val,
		input logic [WORD_W-1:0] front, input logic [WORD_W-1:0] back,
		input logic [COUNT_W-1:0] count, input status_t st);
		row_t row;
		row.op     = op;
		row.val    = val;
		row.pinned = 1'b1;
		row.want   = '{front, back, count, st};
		plan.push_back(row);
	endtask

	// Drive one beat after a random gap; returns at the falling edge after it
	task automatic send_beat(input op_t op, input logic [WORD_W-1:0] val,
		input bit pinned, input snap_t want);
		int gap;
		if (src_calm > 0) begin
			src_calm--;
			gap = 0;
		end else begin
			gap = draw_gap();
			if ($urandom_range(0, 49) == 0)
				src_calm = $urandom_range(20, 80);
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pin_valid = pinned;
		pin_snap  = want;
		req_ch.valid      <= 1'b1;
		req_ch.operation  <= op;
		req_ch.push_value <= val;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Sink side: random stalls with calm stretches
	initial begin : sink_stalls
		int stall;
		stall = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (snk_calm > 0) begin
					snk_calm--;
				end else begin
					stall = draw_gap();
					if ($urandom_range(0, 49) == 0)
						snk_calm = $urandom_range(20, 80);
				end
			end
		end
	end

	// Predict on each accepted request, check each accepted snapshot
	always @(posedge clk) begin : scoreboard
		snap_t want;
		snap_t got;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				advance_deque(op_t'(req_ch.operation), req_ch.push_value, want);
				if (pin_valid)
					want = pin_snap;
				pending_snaps.push_back(want);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.front = rsp_ch.front_word;
				got.back  = rsp_ch.back_word;
				got.count = rsp_ch.entry_count;
				got.st    = status_t'(rsp_ch.status);
				if (pending_snaps.size() == 0) begin
					fault_count++;
					$display("%0t: snapshot with nothing expected, actual %h %h %0d %0d",
						$time, got.front, got.back, got.count, got.st);
				end else begin
					want = pending_snaps[0];
					pending_snaps.delete(0);
					check_field("front_word", want.front, got.front);
					check_field("back_word", want.back, got.back);
					check_field("entry_count", 32'(want.count), 32'(got.count));
					check_field("status", 32'(want.st), 32'(got.st));
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		row_t        row;
		snap_t       no_snap;
		op_t         op;
		int unsigned trend;
		int          r;
		bit          push;

		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.operation  = OP_PUSH_BACK;
		req_ch.push_value = '0;
		no_snap           = '{'1, '1, '0, ST_DONE};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty pops, extremes at both ends, drain back to empty
		add_pinned(OP_POP_FRONT, 32'h1234_5678, '1, '1, 5'd0, ST_EMPTY);
		add_pinned(OP_POP_BACK, 32'hFFFF_FFFF, '1, '1, 5'd0, ST_EMPTY);
		add_pinned(OP_PUSH_BACK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1,
			ST_DONE);
		add_pinned(OP_PUSH_FRONT, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 5'd2,
			ST_DONE);
		add_row(OP_PUSH_FRONT, 32'hFFFF_FFFF);
		add_row(OP_POP_BACK, 32'h0);
		add_row(OP_POP_FRONT, 32'h0);
		add_pinned(OP_POP_BACK, 32'hA5A5_A5A5, '1, '1, 5'd0, ST_DONE);

		// Fill to the brim from both ends, wrapping the ring both ways
		for (int i = 0; i < DEPTH; i++)
			add_row(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK,
				(32'h1 << (2 * i + 1)) ^ (i[1] ? 32'hAAAA_AAAA : 32'h5555_0000));

		// Pushes on a full queue are dropped
		add_row(OP_PUSH_BACK, 32'h0);
		add_row(OP_PUSH_FRONT, 32'h5555_5555);

		foreach (plan[i]) begin
			row = plan[i];
			send_beat(row.op, row.val, row.pinned, row.want);
		end

		// Random traffic: filling, draining and balanced phases
		trend = 1;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if ($urandom_range(0, 39) == 0)
				trend = $urandom_range(0, 2);
			r = $urandom_range(0, 99);
			case (trend)
				0: push = (r < 75);
				1: push = (r < 25);
				default: push = (r < 50);
			endcase
			if (push)
				op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
			else
				op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
			send_beat(op, pick_word(), 1'b0, no_snap);
		end
		req_ch.valid <= 1'b0;

		// Drain, then allow for the two-stage pipeline
		while (pending_snaps.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/deq_pkg.sv
sv/deq_if.sv
sv/deq_ram.sv
sv/deq_ctrl.sv
sv/double_ended_queue_core.sv
sim/double_ended_queue_core_test.sv
